// ===== rtl/core/cvf_pkg.sv =====
// ----------------------------------------------------------------------------
// Colour video fetch package
// Shared types, codes and address constants for the colour video fetch and
// port unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cvf_pkg;

   // Item kinds carried in the action field.
   typedef enum logic [1:0] {
      ACT_FETCH = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_RAM_LOW      = 3'd0,
      CSR_RAM_MID      = 3'd1,
      CSR_COLOUR_RAM   = 3'd2,
      CSR_CHAR_BOARD   = 3'd3,
      CSR_DIRECT_PIXEL = 3'd4
   } csr_index_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 1;

   // Address constants.
   localparam logic [15:0] COLOUR_PORT     = 16'h7FEF;
   localparam logic [15:0] CHAR_BOARD_BASE = 16'h8400;
   localparam logic [15:0] CHARSET_MASK    = 16'h3E00;
   localparam logic [15:0] INV_SET_MASK    = 16'hE100;
   localparam logic [15:0] INV_SET_MATCH   = 16'h2100;
   localparam logic [15:0] PC_ATTR_MASK    = 16'h3FFF;
   localparam logic [5:0]  ATTR_BASE_HI    = 6'b110000;
   localparam logic [1:0]  ATTR_PAGE_HI    = 2'b11;
   localparam logic [3:0]  BORDER_RESET    = 4'd15;

   // One accepted input item.
   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  data;
      logic [15:0] ir_value;
      logic [2:0]  line_count;
      logic        sync_active;
      logic [4:0]  joystick_buttons;
      logic [7:0]  mask_in;
   } item_type;

   // One result item.
   typedef struct packed {
      logic        pixel_valid;
      logic [15:0] pixel_address;
      logic        pixel_invert;
      logic        attr_valid;
      logic [15:0] attr_address;
      logic [7:0]  read_byte;
      logic [7:0]  read_mask;
      logic [3:0]  border_colour;
   } result_type;

   // Configuration and colour state seen by the datapath.
   typedef struct packed {
      logic       ram_low_window_on;
      logic       ram_mid_window_on;
      logic       colour_ram_on;
      logic       char_board_on;
      logic       direct_pixel_on;
      logic       colour_on;
      logic       screen_attr_mode;
      logic [3:0] border;
   } ctrl_type;

   // Colour state update from a port write.
   typedef struct packed {
      logic       write;
      logic       colour_on;
      logic       screen_attr_mode;
      logic [3:0] border;
   } update_type;

endpackage

`default_nettype wire

// ===== rtl/core/cvf_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one input item of the colour video unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] address;
   logic [7:0]  data;
   logic [15:0] ir_value;
   logic [2:0]  line_count;
   logic        sync_active;
   logic [4:0]  joystick_buttons;
   logic [7:0]  mask_in;

   modport source (
      output valid, action, address, data, ir_value, line_count, sync_active,
             joystick_buttons, mask_in,
      input  ready
   );

   modport sink (
      input  valid, action, address, data, ir_value, line_count, sync_active,
             joystick_buttons, mask_in,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/cvf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries one result item of the colour video unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvf_rsp_if;
   logic        valid;
   logic        ready;
   logic        pixel_valid;
   logic [15:0] pixel_address;
   logic        pixel_invert;
   logic        attr_valid;
   logic [15:0] attr_address;
   logic [7:0]  read_byte;
   logic [7:0]  read_mask;
   logic [3:0]  border_colour;

   modport source (
      output valid, pixel_valid, pixel_address, pixel_invert, attr_valid,
             attr_address, read_byte, read_mask, border_colour,
      input  ready
   );

   modport sink (
      input  valid, pixel_valid, pixel_address, pixel_invert, attr_valid,
             attr_address, read_byte, read_mask, border_colour,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/cvf_regs.sv =====
// ----------------------------------------------------------------------------
// Control and colour state registers
// Holds the configuration bits and the colour enable, attribute mode and
// border state that port writes change.
// ----------------------------------------------------------------------------
`default_nettype none

module cvf_regs
   import cvf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire update_type             update,
   output ctrl_type                    ctrl
);

   ctrl_type ctrl_ff;
   ctrl_type ctrl_in;

   // Configuration writes are to arrive only while idle (the block does not enforce this); they take priority.
   always_comb begin
      ctrl_in = ctrl_ff;
      if (update.write) begin
         ctrl_in.colour_on        = update.colour_on;
         ctrl_in.screen_attr_mode = update.screen_attr_mode;
         ctrl_in.border           = update.border;
      end
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RAM_LOW:      ctrl_in.ram_low_window_on = csr_write_data[0];
            CSR_RAM_MID:      ctrl_in.ram_mid_window_on = csr_write_data[0];
            CSR_COLOUR_RAM: begin
               ctrl_in.colour_ram_on = csr_write_data[0];
               // Turning the colour RAM off drops colour and whitens the border.
               if (!csr_write_data[0]) begin
                  ctrl_in.colour_on = 1'b0;
                  ctrl_in.border    = BORDER_RESET;
               end
            end
            CSR_CHAR_BOARD:   ctrl_in.char_board_on     = csr_write_data[0];
            CSR_DIRECT_PIXEL: ctrl_in.direct_pixel_on   = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '{ram_low_window_on: 1'b0,
                      ram_mid_window_on: 1'b0,
                      colour_ram_on:     1'b0,
                      char_board_on:     1'b0,
                      direct_pixel_on:   1'b0,
                      colour_on:         1'b0,
                      screen_attr_mode:  1'b0,
                      border:            BORDER_RESET};
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl = ctrl_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cvf_exec.sv =====
// ----------------------------------------------------------------------------
// Item execution logic
// Decodes one item into its result: video fetch addresses, colour port
// write and keyboard/joystick port read.
// ----------------------------------------------------------------------------
`default_nettype none

module cvf_exec
   import cvf_pkg::*;
(
   input  wire item_type   item,
   input  wire ctrl_type   ctrl,
   output result_type      result,
   output update_type      update
);

   logic        inv;
   logic [8:0]  sub_base;
   logic        add_inv_set;
   logic [9:0]  sub_char;
   logic [9:0]  sub_full;
   logic        direct_hit;
   logic [15:0] fetch_address;
   logic [15:0] attr_addr;
   logic [7:0]  mine;
   logic [7:0]  rd_byte;
   logic [7:0]  rd_mask;
   logic        port_hit;

   // Pixel byte address selection.
   always_comb begin
      inv        = item.data[7];
      sub_base   = {item.data[5:0], item.line_count};
      direct_hit = ctrl.direct_pixel_on &&
                   ((item.ir_value[15:13] == 3'b001 && ctrl.ram_low_window_on) ||
                    (item.ir_value[15:14] == 2'b01 && ctrl.ram_mid_window_on));
      add_inv_set = !ctrl.direct_pixel_on && inv && ctrl.ram_low_window_on &&
                    ((item.ir_value & INV_SET_MASK) == INV_SET_MATCH);
      sub_char    = {add_inv_set, sub_base};
      if (ctrl.char_board_on) begin
         sub_full      = {inv, sub_base};
         fetch_address = CHAR_BOARD_BASE + {6'd0, sub_full};
      end else if (direct_hit) begin
         sub_full      = '0;
         fetch_address = item.ir_value;
      end else begin
         sub_full      = sub_char;
         fetch_address = (item.ir_value & CHARSET_MASK) + {6'd0, sub_char};
      end
      // Attribute bytes live in the top 16K.
      if (ctrl.screen_attr_mode) begin
         attr_addr = {ATTR_PAGE_HI, item.address[13:0] & PC_ATTR_MASK[13:0]};
      end else begin
         attr_addr = {ATTR_BASE_HI, sub_full};
      end
   end

   // Port read: colour-present bit or joystick merged into keyboard rows.
   always_comb begin
      mine    = '0;
      rd_byte = item.data;
      rd_mask = item.mask_in;
      if (item.address[0]) begin
         if (item.address == COLOUR_PORT) begin
            if (ctrl.colour_ram_on) begin
               rd_byte[5] = 1'b0;
            end
            rd_mask[5] = 1'b1;
         end
      end else if (!(item.address[11] && item.address[12])) begin
         if (!item.address[11]) begin
            mine[4] = item.joystick_buttons[1];
         end
         if (!item.address[12]) begin
            mine[2] = mine[2] | item.joystick_buttons[0];
            mine[4] = mine[4] | item.joystick_buttons[2];
            mine[3] = mine[3] | item.joystick_buttons[3];
            mine[0] = mine[0] | item.joystick_buttons[4];
         end
         rd_byte = rd_byte & ~mine;
         rd_mask = rd_mask | mine;
      end
   end

   // Result and state update per item kind.
   always_comb begin
      result        = '0;
      update        = '0;
      port_hit      = (item.address == COLOUR_PORT) && ctrl.colour_ram_on;
      update.colour_on        = item.data[5];
      update.screen_attr_mode = item.data[4];
      update.border           = item.data[5] ? item.data[3:0] : BORDER_RESET;
      case (item.action)
         ACT_FETCH: begin
            if (!item.sync_active) begin
               result.pixel_valid   = 1'b1;
               result.pixel_address = fetch_address;
               result.pixel_invert  = inv;
               if (ctrl.colour_on) begin
                  result.attr_valid   = 1'b1;
                  result.attr_address = attr_addr;
               end
            end
         end
         ACT_WRITE: begin
            update.write = port_hit;
         end
         ACT_READ: begin
            result.read_byte = rd_byte;
            result.read_mask = rd_mask;
         end
         default: ;
      endcase
      // The border reported is the one after this item.
      result.border_colour = update.write ? update.border : ctrl.border;
   end

endmodule

`default_nettype wire

// ===== rtl/core/colour_video_fetch_and_port_unit.sv =====
// ----------------------------------------------------------------------------
// Colour video fetch and port unit
// Throughput: one item per cycle while the result side is ready; input register, decode, result register.
// A stalled result holds its register while one more item waits at the input.
// Reset (synchronous, active high) clears the pipeline, all configuration
// bits and colour state; the border returns to bright white.
// ----------------------------------------------------------------------------
`default_nettype none

module colour_video_fetch_and_port_unit
   import cvf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   cvf_req_if.sink                     req_channel,
   cvf_rsp_if.source                   rsp_channel,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   req_item;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_result_ff;
   result_type exec_result;
   update_type exec_update;
   update_type update;
   ctrl_type   ctrl;
   logic       advance;
   logic       take;

   // Gather the request payload.
   assign req_item = '{
      action:           req_channel.action,
      address:          req_channel.address,
      data:             req_channel.data,
      ir_value:         req_channel.ir_value,
      line_count:       req_channel.line_count,
      sync_active:      req_channel.sync_active,
      joystick_buttons: req_channel.joystick_buttons,
      mask_in:          req_channel.mask_in
   };

   // Pipeline handshake: the item moves on when the result register is free.
   assign advance           = in_valid_ff && (!out_valid_ff || rsp_channel.ready);
   assign req_channel.ready = !in_valid_ff || advance;
   assign take              = req_channel.valid && req_channel.ready;
   assign in_valid_in       = take || (in_valid_ff && !advance);
   assign out_valid_in      = advance || (out_valid_ff && !rsp_channel.ready);

   // State changes only when the item actually moves to the result register.
   always_comb begin
      update       = exec_update;
      update.write = exec_update.write && advance;
   end

   cvf_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .update           (update),
      .ctrl             (ctrl)
   );

   cvf_exec u_exec (
      .item   (in_item_ff),
      .ctrl   (ctrl),
      .result (exec_result),
      .update (exec_update)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_result_ff <= exec_result;
      end
   end

   // Result channel.
   assign rsp_channel.valid         = out_valid_ff;
   assign rsp_channel.pixel_valid   = out_result_ff.pixel_valid;
   assign rsp_channel.pixel_address = out_result_ff.pixel_address;
   assign rsp_channel.pixel_invert  = out_result_ff.pixel_invert;
   assign rsp_channel.attr_valid    = out_result_ff.attr_valid;
   assign rsp_channel.attr_address  = out_result_ff.attr_address;
   assign rsp_channel.read_byte     = out_result_ff.read_byte;
   assign rsp_channel.read_mask     = out_result_ff.read_mask;
   assign rsp_channel.border_colour = out_result_ff.border_colour;

   // Colour can only be on while the colour RAM is enabled.
   a_colour_needs_ram: assert property (@(posedge clock) disable iff (reset)
      ctrl.colour_on |-> ctrl.colour_ram_on)
      else $error("colour on without colour RAM");

   // With colour off the border is bright white.
   a_border_white: assert property (@(posedge clock) disable iff (reset)
      !ctrl.colour_on |-> (ctrl.border == BORDER_RESET))
      else $error("border not white while colour is off");

   // An attribute fetch always comes with a pixel fetch.
   a_attr_with_pixel: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.attr_valid) |-> out_result_ff.pixel_valid)
      else $error("attribute fetch without pixel fetch");

   // A held input item stays in place until it can advance.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input item lost while stalled");

endmodule

`default_nettype wire

// ===== dv/colour_video_fetch_and_port_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Colour video fetch and port unit testbench
// Drives video fetches, colour port writes and port reads through the request
// channel under random source gaps and result stalls. Every result is checked
// field by field against an in-order prediction kept in step with the
// configuration writes made between phases.
// ----------------------------------------------------------------------------

module colour_video_fetch_and_port_unit_test;
   import cvf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   cvf_req_if req_ch ();
   cvf_rsp_if rsp_ch ();

   colour_video_fetch_and_port_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_ch),
      .rsp_channel      (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predicted configuration and colour state.
   logic       low_ram_en;
   logic       mid_ram_en;
   logic       colour_ram_en;
   logic       char_board_en;
   logic       direct_pixel_en;
   logic       colour_enabled;
   logic       attr_from_pc;
   logic [3:0] border_now;

   result_type pending_results[$];

   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned fetch_count;
   int unsigned write_count;
   int unsigned read_count;
   int unsigned setting_count;
   int unsigned cycle_count = 0;
   int unsigned gap_pct;
   int unsigned stall_pct;
   int unsigned stall_left = 0;
   bit          calm;

   // Clock generation.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d results outstanding", $time,
                  pending_results.size());
         $display("FAIL");
         $finish;
      end
   end

   // Result side: ready drops in random bursts unless the run is calm.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left   <= $urandom_range(0, 10);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare one field and report a mismatch.
   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // Check each accepted result against the oldest prediction.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: result with none expected, expected none actual %h", $time,
                     rsp_ch.pixel_address);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            report_field("pixel_valid", 16'(want.pixel_valid), 16'(rsp_ch.pixel_valid));
            report_field("pixel_address", want.pixel_address, rsp_ch.pixel_address);
            report_field("pixel_invert", 16'(want.pixel_invert), 16'(rsp_ch.pixel_invert));
            report_field("attr_valid", 16'(want.attr_valid), 16'(rsp_ch.attr_valid));
            report_field("attr_address", want.attr_address, rsp_ch.attr_address);
            report_field("read_byte", 16'(want.read_byte), 16'(rsp_ch.read_byte));
            report_field("read_mask", 16'(want.read_mask), 16'(rsp_ch.read_mask));
            report_field("border_colour", 16'(want.border_colour),
                         16'(rsp_ch.border_colour));
         end
      end
   end

   // Work out the result of one item and advance the colour state.
   function automatic result_type predict_result(input item_type it);
      result_type  r;
      logic [15:0] sub;
      logic [15:0] ir;
      logic [7:0]  bus;
      logic [7:0]  drive;
      logic [7:0]  mine;
      r   = '0;
      ir  = it.ir_value;
      bus = it.data;
      drive = it.mask_in;
      mine  = 8'h00;
      case (it.action)
         ACT_FETCH: begin
            if (!it.sync_active) begin
               sub = {7'd0, it.data[5:0], 3'd0} + {13'd0, it.line_count};
               if (char_board_en) begin
                  if (it.data[7]) sub = sub + 16'h0200;
                  r.pixel_address = CHAR_BOARD_BASE + sub;
               end else if (direct_pixel_en &&
                            ((ir >= 16'h2000 && ir < 16'h4000 && low_ram_en) ||
                             (ir >= 16'h4000 && ir < 16'h8000 && mid_ram_en))) begin
                  sub = 16'h0000;
                  r.pixel_address = ir;
               end else begin
                  // The inverted half of the 128-character set lives in low RAM.
                  if (!direct_pixel_en && it.data[7] &&
                      (ir & INV_SET_MASK) == INV_SET_MATCH && low_ram_en)
                     sub = sub + 16'h0200;
                  r.pixel_address = (ir & CHARSET_MASK) + sub;
               end
               r.pixel_valid  = 1'b1;
               r.pixel_invert = it.data[7];
               if (colour_enabled) begin
                  r.attr_valid   = 1'b1;
                  r.attr_address = attr_from_pc ? (16'hC000 | (it.address & PC_ATTR_MASK))
                                                : (16'hC000 + sub);
               end
            end
         end
         ACT_WRITE: begin
            if (it.address == COLOUR_PORT && colour_ram_en) begin
               colour_enabled = it.data[5];
               attr_from_pc   = it.data[4];
               border_now     = it.data[5] ? it.data[3:0] : BORDER_RESET;
            end
         end
         ACT_READ: begin
            if (it.address[0]) begin
               if (it.address == COLOUR_PORT) begin
                  if (colour_ram_en) bus[5] = 1'b0;
                  drive[5] = 1'b1;
               end
            end else if (!(it.address[11] && it.address[12])) begin
               // Joystick buttons pull keyboard row bits low.
               if (!it.address[11])
                  mine = mine | {3'b000, it.joystick_buttons[1], 4'b0000};
               if (!it.address[12])
                  mine = mine | {3'b000, it.joystick_buttons[2], it.joystick_buttons[3],
                                 it.joystick_buttons[0], 1'b0, it.joystick_buttons[4]};
               bus   = bus & ~mine;
               drive = drive | mine;
            end
            r.read_byte = bus;
            r.read_mask = drive;
         end
         default: ;
      endcase
      r.border_colour = border_now;
      return r;
   endfunction

   function automatic item_type make_item(input logic [1:0] action,
                                          input logic [15:0] address,
                                          input logic [7:0] data,
                                          input logic [15:0] ir_value,
                                          input logic [2:0] line_count,
                                          input logic sync_active,
                                          input logic [4:0] joystick_buttons,
                                          input logic [7:0] mask_in);
      item_type it;
      it.action           = action;
      it.address          = address;
      it.data             = data;
      it.ir_value         = ir_value;
      it.line_count       = line_count;
      it.sync_active      = sync_active;
      it.joystick_buttons = joystick_buttons;
      it.mask_in          = mask_in;
      return it;
   endfunction

   // Send one item, with an optional leading gap, and predict its result.
   task automatic send_item(input item_type it);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.action           <= it.action;
      req_ch.address          <= it.address;
      req_ch.data             <= it.data;
      req_ch.ir_value         <= it.ir_value;
      req_ch.line_count       <= it.line_count;
      req_ch.sync_active      <= it.sync_active;
      req_ch.joystick_buttons <= it.joystick_buttons;
      req_ch.mask_in          <= it.mask_in;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(predict_result(it));
      case (it.action)
         ACT_FETCH: fetch_count++;
         ACT_WRITE: write_count++;
         ACT_READ:  read_count++;
         default: ;
      endcase
   endtask

   // Stop sending and wait until every predicted result has arrived.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_RAM_LOW:      low_ram_en = val;
         CSR_RAM_MID:      mid_ram_en = val;
         CSR_COLOUR_RAM: begin
            colour_ram_en = val;
            if (!val) begin
               colour_enabled = 1'b0;
               border_now     = BORDER_RESET;
            end
         end
         CSR_CHAR_BOARD:   char_board_en = val;
         CSR_DIRECT_PIXEL: direct_pixel_en = val;
         default: ;
      endcase
   endtask

   // Change all registers once the block has gone idle.
   task automatic set_config(input logic low, input logic mid, input logic colour,
                             input logic board, input logic direct);
      wait_drained();
      write_register(CSR_RAM_LOW, low);
      write_register(CSR_RAM_MID, mid);
      write_register(CSR_COLOUR_RAM, colour);
      write_register(CSR_CHAR_BOARD, board);
      write_register(CSR_DIRECT_PIXEL, direct);
      setting_count++;
   endtask

   // Random item, biased toward the colour port and the RAM windows.
   function automatic item_type random_item();
      item_type    it;
      int unsigned pick;
      it.address          = 16'($urandom_range(0, 16'hFFFF));
      it.data             = 8'($urandom_range(0, 8'hFF));
      it.ir_value         = 16'($urandom_range(0, 16'hFFFF));
      it.line_count       = 3'($urandom_range(0, 7));
      it.sync_active      = ($urandom_range(0, 9) == 0);
      it.joystick_buttons = 5'($urandom_range(0, 31));
      it.mask_in          = 8'($urandom_range(0, 8'hFF));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         it.action = ACT_FETCH;
         case ($urandom_range(0, 5))
            0: it.ir_value = 16'($urandom_range(16'h2000, 16'h3FFF));
            1: it.ir_value = 16'($urandom_range(16'h4000, 16'h7FFF));
            2: it.ir_value = 16'($urandom_range(16'h8000, 16'hFFFF));
            3: it.ir_value = 16'($urandom_range(16'h0000, 16'h1FFF));
            4: it.ir_value = (it.ir_value & ~INV_SET_MASK) | INV_SET_MATCH;
            default: ;
         endcase
      end else if (pick < 65) begin
         it.action = ACT_WRITE;
         if ($urandom_range(0, 9) < 7) it.address = COLOUR_PORT;
      end else if (pick < 95) begin
         it.action = ACT_READ;
         case ($urandom_range(0, 3))
            0: it.address = COLOUR_PORT;
            1: it.address[0] = 1'b1;
            default: it.address[0] = 1'b0;
         endcase
      end else begin
         it.action = ACT_NONE;
      end
      return it;
   endfunction

   // Items right after reset, with every register at its reset value.
   task automatic test_reset_state();
      send_item(make_item(ACT_FETCH, 16'h0000, 8'h00, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_FETCH, 16'hFFFF, 8'hFF, 16'hFFFF, 3'd7, 1'b0, 5'h1F, 8'hFF));
      send_item(make_item(ACT_FETCH, 16'h1234, 8'h55, 16'h2100, 3'd3, 1'b1, 5'h00, 8'h00));
      send_item(make_item(ACT_READ, COLOUR_PORT, 8'hFF, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_WRITE, COLOUR_PORT, 8'h27, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_NONE, 16'hFFFF, 8'hFF, 16'hFFFF, 3'd7, 1'b1, 5'h1F, 8'hFF));
   endtask

   // Colour port writes: enable, wrong port, attribute mode, colour off.
   task automatic test_colour_port();
      set_config(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      send_item(make_item(ACT_WRITE, COLOUR_PORT, 8'h25, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_WRITE, 16'h7FEE, 8'h3F, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_FETCH, 16'h0123, 8'h07, 16'h1E00, 3'd2, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_WRITE, COLOUR_PORT, 8'h3A, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_FETCH, 16'h5ABC, 8'h11, 16'h1E00, 3'd5, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_WRITE, COLOUR_PORT, 8'h0F, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_WRITE, COLOUR_PORT, 8'h25, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
   endtask

   // Character set, inverted set, direct pixel and character board fetches.
   task automatic test_fetch_modes();
      send_item(make_item(ACT_FETCH, 16'h0000, 8'h81, 16'h2100, 3'd1, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_FETCH, 16'h0000, 8'h81, 16'h2000, 3'd1, 1'b0, 5'h00, 8'h00));
      set_config(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
      send_item(make_item(ACT_FETCH, 16'h0000, 8'h82, 16'h3000, 3'd4, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_FETCH, 16'h0000, 8'h02, 16'h6000, 3'd4, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_FETCH, 16'h0000, 8'hBF, 16'h9000, 3'd7, 1'b0, 5'h00, 8'h00));
      send_item(make_item(ACT_FETCH, 16'h0000, 8'h83, 16'h1000, 3'd6, 1'b0, 5'h00, 8'h00));
      set_config(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      send_item(make_item(ACT_FETCH, 16'h0000, 8'h85, 16'h3000, 3'd2, 1'b0, 5'h00, 8'h00));
      // Clearing the colour RAM bit turns colour off and whitens the border.
      set_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_item(make_item(ACT_FETCH, 16'h0000, 8'hC0, 16'h0000, 3'd0, 1'b0, 5'h00, 8'h00));
   endtask

   // Colour-present bit, pass-through addresses and joystick rows.
   task automatic test_port_reads();
      set_config(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      send_item(make_item(ACT_READ, COLOUR_PORT, 8'hFF, 16'h0000, 3'd0, 1'b0, 5'h1F, 8'h00));
      send_item(make_item(ACT_READ, 16'h1235, 8'hA5, 16'h0000, 3'd0, 1'b0, 5'h1F, 8'h5A));
      send_item(make_item(ACT_READ, 16'hF8FE, 8'hFF, 16'h0000, 3'd0, 1'b0, 5'h1F, 8'h00));
      send_item(make_item(ACT_READ, 16'hF7FE, 8'hFF, 16'h0000, 3'd0, 1'b0, 5'h1F, 8'h00));
      send_item(make_item(ACT_READ, 16'hEFFE, 8'hFF, 16'h0000, 3'd0, 1'b0, 5'h1F, 8'h00));
      send_item(make_item(ACT_READ, 16'hE7FE, 8'hFF, 16'h0000, 3'd0, 1'b0, 5'h1F, 8'h00));
   endtask

   // Random phases, each under its own register setting and idling rates.
   task automatic test_random_phases();
      int unsigned phase;
      int unsigned n;
      int unsigned rates[4] = '{0, 5, 20, 50};
      for (phase = 0; phase < 10; phase++) begin
         if (phase == 0)
            set_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
         else if (phase == 1)
            set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
         else
            set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 99) < 85), ($urandom_range(0, 3) == 0),
                       1'($urandom_range(0, 1)));
         gap_pct   = rates[$urandom_range(0, 3)];
         stall_pct = rates[$urandom_range(0, 3)];
         for (n = 0; n < 155; n++) begin
            if (n == 77 && phase % 3 == 0) wait_drained();
            send_item(random_item());
         end
      end
   endtask

   // The sender holds off until every result is in, then resumes.
   task automatic test_pause_until_drained();
      int unsigned n;
      gap_pct   = 20;
      stall_pct = 20;
      for (n = 0; n < 20; n++) send_item(random_item());
      wait_drained();
      for (n = 0; n < 20; n++) send_item(random_item());
   endtask

   // Back-to-back items with the result side always ready.
   task automatic test_steady_tail();
      int unsigned n;
      set_config(1'b1, 1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
      calm = 1'b1;
      for (n = 0; n < 110; n++) send_item(random_item());
   endtask

   initial begin
      reset                   <= 1'b1;
      csr_write_enable        <= 1'b0;
      csr_index               <= '0;
      csr_write_data          <= '0;
      req_ch.valid            <= 1'b0;
      req_ch.action           <= ACT_NONE;
      req_ch.address          <= '0;
      req_ch.data             <= '0;
      req_ch.ir_value         <= '0;
      req_ch.line_count       <= '0;
      req_ch.sync_active      <= 1'b0;
      req_ch.joystick_buttons <= '0;
      req_ch.mask_in          <= '0;
      low_ram_en      = 1'b0;
      mid_ram_en      = 1'b0;
      colour_ram_en   = 1'b0;
      char_board_en   = 1'b0;
      direct_pixel_en = 1'b0;
      colour_enabled  = 1'b0;
      attr_from_pc    = 1'b0;
      border_now      = BORDER_RESET;
      fetch_count     = 0;
      write_count     = 0;
      read_count      = 0;
      setting_count   = 0;
      gap_pct         = 0;
      stall_pct       = 0;
      calm            = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_colour_port();
      test_fetch_modes();
      test_port_reads();
      test_random_phases();
      test_pause_until_drained();
      test_steady_tail();
      wait_drained();

      $display("Checked %0d results: %0d fetches, %0d port writes, %0d port reads.",
               results_checked, fetch_count, write_count, read_count);
      $display("Ran under %0d register settings with random gaps and stalls.",
               setting_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule
